### rtl/core/jmsi_pkg.sv
// Shared types, codes and reset values for the joint motion slew integrator.
package jmsi_pkg;

	localparam int MAX_JOINTS_DEF = 8;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	// Command codes
	localparam logic [2:0] FN_TICK     = 3'd0;
	localparam logic [2:0] FN_SET_GOAL = 3'd1;
	localparam logic [2:0] FN_SET_POS  = 3'd2;
	localparam logic [2:0] FN_SET_VEL  = 3'd3;
	localparam logic [2:0] FN_READ     = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TICK_TIME  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_VEL_TMO    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_JOINTS_USE = CFG_IDX_W'(3);

	// Configuration reset values
	localparam logic [30:0] MAX_STEP_RST   = 31'd66;
	localparam logic [15:0] TICK_TIME_RST  = 16'd66;
	localparam logic [15:0] VEL_TMO_RST    = 16'd500;
	localparam logic [3:0]  JOINTS_USE_RST = 4'd8;

	// Per-element operation carried down the update pipeline
	typedef enum logic [1:0] {
		OP_NONE = 2'b00,
		OP_READ = 2'b01,
		OP_POS  = 2'b10,
		OP_VEL  = 2'b11
	} op_t;

	typedef struct packed {
		logic vld;
		logic last;
		op_t  op;
		logic ok;
		logic err;
		logic we_goal;
		logic we_pos;
		logic we_vel;
	} ctl_t;

	typedef struct packed {
		logic pos;
		logic goal;
		logic vel;
	} wr_t;

endpackage

### rtl/core/jmsi_if.sv
// Channel interfaces: command input, result output and configuration write.
interface jmsi_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         func;
	logic [2:0]         joint_index;
	logic signed [31:0] value;

	modport source (output valid, func, joint_index, value, input ready);
	modport sink   (input valid, func, joint_index, value, output ready);
endinterface

interface jmsi_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] read_value;
	logic               status;

	modport source (output valid, read_value, status, input ready);
	modport sink   (input valid, read_value, status, output ready);
endinterface

interface jmsi_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [jmsi_pkg::CFG_IDX_W-1:0]  index;
	logic [jmsi_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/joint_motion_slew_integrator_core.sv
// Top level of the joint motion slew integrator: config registers, write port, result register.
//
// Usage:
//   cmd  - command channel (func, joint_index, value). One transaction per command.
//          func: tick, set goal, set position, set velocity, read position.
//   rsp  - result channel (read_value, status). Exactly one transaction per command,
//          in command order. status flags a joint index not below the active count on set and read.
//   cfg  - register write channel (index, data), always ready. Write only while idle.
// Flow:
//   A command passes the stage-1 register, the memory read and the step register to
//   its result in the output register, and cmd is ready again in the same cycle. A
//   tick that moves joints walks the n active joints one per cycle through the memory
//   read, step and write-back pipeline; a tick that changes nothing issues a single
//   empty element. The next command waits until the previous one has drained
//   the pipeline, so no read can meet a pending write to the same joint.
// Reset:
//   arst_n clears configuration to defaults, mode to position mode, the timeout
//   counter, and the per-entry valid bits, so every joint reads back as zero.
// Stall:
//   A result waits in the output register while rsp is not ready; the next command
//   is still accepted and runs up to its last pipeline stage, which then holds.
module joint_motion_slew_integrator_core #(
	parameter int MAX_JOINTS = jmsi_pkg::MAX_JOINTS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	jmsi_in_if.sink  cmd,
	jmsi_out_if.source rsp,
	jmsi_cfg_if.sink cfg
);
	import jmsi_pkg::*;

	localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

	// Configuration registers
	logic [30:0] max_step_q;
	logic [15:0] tick_time_q;
	logic [15:0] vel_tmo_q;
	logic [3:0]  joints_use_q;

	// Pipeline control and data
	ctl_t               ctl_s1;
	ctl_t               ctl_s3;
	logic [AW-1:0]      addr_s1;
	logic [AW-1:0]      addr_s3;
	logic signed [31:0] value_s1;
	logic signed [31:0] pos_new;
	logic signed [31:0] rd_value;
	logic signed [31:0] pos_rd;
	logic signed [31:0] goal_rd;
	logic signed [31:0] vel_rd;

	logic               adv;
	logic               done;
	logic               s3_wen;
	logic               cmd_wen;
	wr_t                wr_en;
	logic [AW-1:0]      wr_addr;
	logic signed [31:0] wr_data;

	// Result register
	logic               out_valid_q;
	logic signed [31:0] out_value_q;
	logic               out_status_q;

	// Configuration write port; always takes the transaction
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_step_q   <= MAX_STEP_RST;
			tick_time_q  <= TICK_TIME_RST;
			vel_tmo_q    <= VEL_TMO_RST;
			joints_use_q <= JOINTS_USE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MAX_STEP:   max_step_q   <= cfg.data[30:0];
				REG_TICK_TIME:  tick_time_q  <= cfg.data[15:0];
				REG_VEL_TMO:    vel_tmo_q    <= cfg.data[15:0];
				REG_JOINTS_USE: joints_use_q <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	// Hold the whole pipeline only when the last element of an item finds the
	// result register full and not being drained.
	assign adv  = !(ctl_s3.vld && ctl_s3.last && out_valid_q && !rsp.ready);
	assign done = ctl_s3.vld && ctl_s3.last && adv;

	jmsi_sequencer #(
		.MAX_JOINTS (MAX_JOINTS),
		.AW         (AW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.adv        (adv),
		.done       (done),
		.vel_tmo    (vel_tmo_q),
		.joints_use (joints_use_q),
		.ctl_s1     (ctl_s1),
		.addr_s1    (addr_s1),
		.value_s1   (value_s1)
	);

	// Single write port: tick write-back from the last stage, command writes from
	// the first. The sequencer keeps the two from ever meeting.
	assign s3_wen  = ctl_s3.vld && adv && (ctl_s3.op == OP_POS || ctl_s3.op == OP_VEL);
	assign cmd_wen = ctl_s1.vld && adv;

	always_comb begin
		wr_en.pos  = s3_wen || (cmd_wen && ctl_s1.we_pos);
		wr_en.goal = cmd_wen && ctl_s1.we_goal;
		wr_en.vel  = cmd_wen && ctl_s1.we_vel;
		wr_addr    = s3_wen ? addr_s3 : addr_s1;
		wr_data    = s3_wen ? pos_new : value_s1;
	end

	jmsi_joint_mem #(
		.MAX_JOINTS (MAX_JOINTS),
		.AW         (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.rd_addr (addr_s1),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.pos_rd  (pos_rd),
		.goal_rd (goal_rd),
		.vel_rd  (vel_rd)
	);

	jmsi_update #(
		.MAX_JOINTS (MAX_JOINTS),
		.AW         (AW)
	) u_upd (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.ctl_s1    (ctl_s1),
		.addr_s1   (addr_s1),
		.pos_rd    (pos_rd),
		.goal_rd   (goal_rd),
		.vel_rd    (vel_rd),
		.max_step  (max_step_q),
		.tick_time (tick_time_q),
		.ctl_s3    (ctl_s3),
		.addr_s3   (addr_s3),
		.pos_new   (pos_new),
		.rd_value  (rd_value)
	);

	// Load the result on the item's last element; drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_value_q  <= rd_value;
			out_status_q <= ctl_s3.err;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = out_value_q;
	assign rsp.status     = out_status_q;

`ifndef NO_ASSERTIONS
	// Tick write-back and command writes never share the write port
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(s3_wen && cmd_wen && (ctl_s1.we_pos || ctl_s1.we_goal || ctl_s1.we_vel)))
		else $error("tick write-back collides with a command write");

	// A new command enters only into an empty pipeline
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |-> (!ctl_s1.vld && !ctl_s3.vld))
		else $error("command accepted while the pipeline is busy");

	// A result is loaded only into a free or draining result register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!out_valid_q || rsp.ready))
		else $error("result register overwritten");
`endif

endmodule

### rtl/core/jmsi_joint_mem.sv
// Joint state memories: position, and goal with velocity, registered read.
module jmsi_joint_mem #(
	parameter int MAX_JOINTS = jmsi_pkg::MAX_JOINTS_DEF,
	parameter int AW         = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic [AW-1:0]      rd_addr,
	input  jmsi_pkg::wr_t      wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  logic signed [31:0] wr_data,
	output logic signed [31:0] pos_rd,
	output logic signed [31:0] goal_rd,
	output logic signed [31:0] vel_rd
);
	import jmsi_pkg::*;

	logic [31:0] pos_mem [MAX_JOINTS];
	logic [63:0] gv_mem  [MAX_JOINTS];

	logic [MAX_JOINTS-1:0] pos_vld_q;
	logic [MAX_JOINTS-1:0] goal_vld_q;
	logic [MAX_JOINTS-1:0] vel_vld_q;

	// Entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_vld_q  <= '0;
			goal_vld_q <= '0;
			vel_vld_q  <= '0;
		end else begin
			if (wr_en.pos)  pos_vld_q[wr_addr]  <= 1'b1;
			if (wr_en.goal) goal_vld_q[wr_addr] <= 1'b1;
			if (wr_en.vel)  vel_vld_q[wr_addr]  <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en.pos)  pos_mem[wr_addr]        <= wr_data;
		if (wr_en.goal) gv_mem[wr_addr][63:32] <= wr_data;
		if (wr_en.vel)  gv_mem[wr_addr][31:0]  <= wr_data;
	end

	// Hold read data while the pipeline stalls
	always_ff @(posedge clk) begin
		if (adv) begin
			pos_rd  <= pos_vld_q[rd_addr]  ? $signed(pos_mem[rd_addr])        : 32'sd0;
			goal_rd <= goal_vld_q[rd_addr] ? $signed(gv_mem[rd_addr][63:32]) : 32'sd0;
			vel_rd  <= vel_vld_q[rd_addr]  ? $signed(gv_mem[rd_addr][31:0])  : 32'sd0;
		end
	end

endmodule

### rtl/core/jmsi_update.sv
// Update datapath: step computation after the memory read, then add and saturate.
module jmsi_update #(
	parameter int MAX_JOINTS = jmsi_pkg::MAX_JOINTS_DEF,
	parameter int AW         = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  jmsi_pkg::ctl_t     ctl_s1,
	input  logic [AW-1:0]      addr_s1,
	input  logic signed [31:0] pos_rd,
	input  logic signed [31:0] goal_rd,
	input  logic signed [31:0] vel_rd,
	input  logic [30:0]        max_step,
	input  logic [15:0]        tick_time,
	output jmsi_pkg::ctl_t     ctl_s3,
	output logic [AW-1:0]      addr_s3,
	output logic signed [31:0] pos_new,
	output logic signed [31:0] rd_value
);
	import jmsi_pkg::*;

	ctl_t               ctl_s2;
	logic [AW-1:0]      addr_s2;
	logic signed [32:0] step_s3;
	logic               cin_s3;
	logic signed [31:0] pos_s3;

	logic signed [48:0] prod;
	logic signed [32:0] diff;
	logic signed [32:0] lim;
	logic signed [32:0] dclamp;
	logic [33:0]        sum;

	// Velocity: Q16.16 * Q0.16, rounded half up as floor plus bit 15
	assign prod = 49'(vel_rd) * 49'($signed({1'b0, tick_time}));

	// Position: exact difference clamped to +/- max_step
	assign diff = $signed({goal_rd[31], goal_rd}) - $signed({pos_rd[31], pos_rd});
	assign lim  = $signed({2'b00, max_step});

	always_comb begin
		dclamp = diff;
		if (diff > lim)
			dclamp = lim;
		else if (diff < -lim)
			dclamp = -lim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s2 <= addr_s1;
			addr_s3 <= addr_s2;
			pos_s3  <= pos_rd;
			if (ctl_s2.op == OP_VEL) begin
				step_s3 <= $signed({prod[47], prod[47:16]});
				cin_s3  <= prod[15];
			end else begin
				step_s3 <= dclamp;
				cin_s3  <= 1'b0;
			end
		end
	end

	assign sum = {{2{pos_s3[31]}}, pos_s3} + {step_s3[32], step_s3} + {33'd0, cin_s3};

	always_comb begin
		if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111)
			pos_new = $signed(sum[31:0]);
		else if (sum[33])
			pos_new = 32'sh8000_0000;
		else
			pos_new = 32'sh7FFF_FFFF;
	end

	assign rd_value = (ctl_s3.op == OP_READ && ctl_s3.ok) ? pos_s3 : 32'sd0;

endmodule

### rtl/core/jmsi_sequencer.sv
// Command sequencer: decode, mode and timeout state, joint walk for ticks.
module jmsi_sequencer #(
	parameter int MAX_JOINTS = jmsi_pkg::MAX_JOINTS_DEF,
	parameter int AW         = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	jmsi_in_if.sink            cmd,
	input  logic               adv,
	input  logic               done,
	input  logic [15:0]        vel_tmo,
	input  logic [3:0]         joints_use,
	output jmsi_pkg::ctl_t     ctl_s1,
	output logic [AW-1:0]      addr_s1,
	output logic signed [31:0] value_s1
);
	import jmsi_pkg::*;

	localparam int CW = ($clog2(MAX_JOINTS + 1) > 4) ? $clog2(MAX_JOINTS + 1) : 4;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_WAIT = 3'b100
	} state_t;

	state_t        state_q;
	logic          mode_q;
	logic [15:0]   cnt_q;
	logic [AW-1:0] walk_q;
	logic [AW-1:0] tk_last_q;
	op_t           tk_op_q;

	logic [CW-1:0] n_act;
	logic          idx_ok;
	logic          integ;
	op_t           tk_op;
	logic [AW-1:0] tk_last;
	logic          accept;
	ctl_t          elem_in;
	ctl_t          elem_walk;

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;

	always_comb begin
		n_act = (CW'(joints_use) > CW'(MAX_JOINTS)) ? CW'(MAX_JOINTS) : CW'(joints_use);
		idx_ok = CW'(cmd.joint_index) < n_act;
		integ  = mode_q && (cnt_q < vel_tmo);

		tk_op = OP_NONE;
		if (n_act != '0) begin
			if (!mode_q)
				tk_op = OP_POS;
			else if (integ)
				tk_op = OP_VEL;
		end
		// A tick that changes nothing issues a single empty element
		tk_last = (tk_op == OP_NONE) ? '0 : AW'(n_act - CW'(1));

		elem_in      = '0;
		elem_in.vld  = 1'b1;
		elem_in.last = 1'b1;
		elem_in.ok   = idx_ok;
		unique case (cmd.func)
			FN_TICK: begin
				elem_in.op   = tk_op;
				elem_in.last = (tk_last == '0);
			end
			FN_SET_GOAL: begin
				elem_in.err     = !idx_ok;
				elem_in.we_goal = idx_ok;
			end
			FN_SET_POS: begin
				elem_in.err     = !idx_ok;
				elem_in.we_goal = idx_ok;
				elem_in.we_pos  = idx_ok;
			end
			FN_SET_VEL: begin
				elem_in.err    = !idx_ok;
				elem_in.we_vel = idx_ok;
			end
			FN_READ: begin
				elem_in.err = !idx_ok;
				elem_in.op  = OP_READ;
			end
			default: begin
				elem_in.ok = 1'b0;
			end
		endcase

		elem_walk      = '0;
		elem_walk.vld  = 1'b1;
		elem_walk.last = (walk_q == tk_last_q);
		elem_walk.op   = tk_op_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mode_q    <= 1'b0;
			cnt_q     <= '0;
			walk_q    <= '0;
			tk_last_q <= '0;
			tk_op_q   <= OP_NONE;
			ctl_s1    <= '0;
		end else begin
			if (accept) begin
				unique case (cmd.func) inside
					FN_TICK: begin
						if (cnt_q != 16'hFFFF) cnt_q <= cnt_q + 16'd1;
					end
					FN_SET_GOAL, FN_SET_POS: begin
						mode_q <= 1'b0;
					end
					FN_SET_VEL: begin
						mode_q <= 1'b1;
						cnt_q  <= '0;
					end
					default: ;
				endcase
			end
			if (adv) begin
				unique case (state_q)
					ST_IDLE: begin
						if (accept) begin
							ctl_s1    <= elem_in;
							tk_op_q   <= tk_op;
							tk_last_q <= tk_last;
							walk_q    <= AW'(1);
							if (cmd.func == FN_TICK && tk_last != '0)
								state_q <= ST_WALK;
							else
								state_q <= ST_WAIT;
						end else begin
							ctl_s1 <= '0;
						end
					end
					ST_WALK: begin
						ctl_s1 <= elem_walk;
						walk_q <= walk_q + AW'(1);
						if (walk_q == tk_last_q) state_q <= ST_WAIT;
					end
					ST_WAIT: begin
						ctl_s1 <= '0;
						if (done) state_q <= ST_IDLE;
					end
					default: begin
						ctl_s1  <= '0;
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (state_q == ST_IDLE) begin
				addr_s1  <= (cmd.func == FN_TICK) ? '0 : AW'(cmd.joint_index);
				value_s1 <= cmd.value;
			end else begin
				addr_s1 <= walk_q;
			end
		end
	end

endmodule
